FILE: hdl/polar_cartesian_vector_register_unit_assert.svh
// assertion macros for the polar / cartesian vector register unit
`ifndef POLAR_CARTESIAN_VECTOR_REGISTER_UNIT_ASSERT_SVH
`define POLAR_CARTESIAN_VECTOR_REGISTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// property that must hold in the same cycle
`define PCVR_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// antecedent in one cycle, consequent in the next
`define PCVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PCVR_ASSERT_NOW(lbl, clk, rstn, prop, msg)
`define PCVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

FILE: hdl/pcvr_pkg.sv
// shared types, constants and angle table for the vector register unit
`timescale 1ns / 1ps

package pcvr_pkg;

  // cordic constants
  localparam int CORDIC_STEPS = 30;
  localparam int GUARD_SHIFT  = 24;
  localparam int INV_GAIN_Q24 = 10188014;
  localparam int IDX_W        = 5;

  // request kinds
  localparam logic [1:0] KIND_X   = 2'd0;
  localparam logic [1:0] KIND_Y   = 2'd1;
  localparam logic [1:0] KIND_MAG = 2'd2;
  localparam logic [1:0] KIND_ANG = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC,
    ST_SQRT,
    ST_VEC,
    ST_ROT_LOAD,
    ST_ROT,
    ST_DONE
  } state_t;

  // multiplier operand select
  typedef enum logic [1:0] {
    MUL_SEL_X,
    MUL_SEL_Y,
    MUL_SEL_GAIN
  } mul_sel_t;

  // square root unit control
  typedef struct packed {
    logic load;
    logic step;
  } sqrt_ctrl_t;

  // cordic unit control
  typedef struct packed {
    logic             load;
    logic             step;
    logic             vectoring;
    logic [IDX_W-1:0] idx;
  } cordic_ctrl_t;

  // atan(2^-i) as a fraction of a turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051D;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/pcvr_isqrt.sv
// bit-serial rounded integer square root, one root bit per step
`timescale 1ns / 1ps

module pcvr_isqrt
  import pcvr_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic                   clk,
  input  sqrt_ctrl_t             ctrl,
  input  logic [2*LENGTH_BITS-1:0] radicand,
  output logic [LENGTH_BITS:0]   root_round
);

  localparam int L = LENGTH_BITS;

  logic [2*L-1:0] rad_r;
  logic [L+1:0]   rem_r;
  logic [L-1:0]   root_r;

  logic [L+1:0]   rem_sh;
  logic [L+1:0]   trial;
  logic           take;

  // next remainder candidate and trial subtrahend
  assign rem_sh = {rem_r[L-1:0], rad_r[2*L-1:2*L-2]};
  assign trial  = {root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  // restoring root iteration
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (ctrl.step) begin
      rad_r  <= {rad_r[2*L-3:0], 2'b00};
      rem_r  <= take ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[L-2:0], take};
    end
  end

  // round half up: remainder above root means next integer is nearer
  assign root_round = {1'b0, root_r} + (L+1)'(rem_r > {2'b00, root_r});

endmodule

FILE: hdl/pcvr_cordic.sv
// shared cordic iteration unit for vectoring and rotation
`timescale 1ns / 1ps

module pcvr_cordic
  import pcvr_pkg::*;
#(
  parameter int DATA_W = 51
) (
  input  logic                     clk,
  input  cordic_ctrl_t             ctrl,
  input  logic signed [DATA_W-1:0] load_x,
  input  logic signed [DATA_W-1:0] load_y,
  input  logic [31:0]              load_z,
  output logic signed [DATA_W-1:0] vx,
  output logic signed [DATA_W-1:0] vy,
  output logic [31:0]              vz
);

  logic signed [DATA_W-1:0] vx_r;
  logic signed [DATA_W-1:0] vy_r;
  logic [31:0]              vz_r;

  logic signed [DATA_W-1:0] dx;
  logic signed [DATA_W-1:0] dy;
  logic [31:0]              da;
  logic                     cw;

  // shifted cross terms and direction of this micro-rotation
  assign dx = vy_r >>> ctrl.idx;
  assign dy = vx_r >>> ctrl.idx;
  assign da = atan_turn(ctrl.idx);
  assign cw = ctrl.vectoring ? ~vy_r[DATA_W-1] : vz_r[31];

  // one micro-rotation per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vx_r <= load_x;
      vy_r <= load_y;
      vz_r <= load_z;
    end else if (ctrl.step) begin
      if (cw) begin
        vx_r <= vx_r + dx;
        vy_r <= vy_r - dy;
        vz_r <= vz_r + da;
      end else begin
        vx_r <= vx_r - dx;
        vy_r <= vy_r + dy;
        vz_r <= vz_r - da;
      end
    end
  end

  assign vx = vx_r;
  assign vy = vy_r;
  assign vz = vz_r;

endmodule

FILE: hdl/polar_cartesian_vector_register_unit.sv
// top level: vector register holding cartesian and polar forms, with sequencer
`timescale 1ns / 1ps
`include "polar_cartesian_vector_register_unit_assert.svh"
// Holds one 2-D vector as x, y, magnitude and angle. Each request on the in_
// stream writes one component (in_tuser = kind: x, y, magnitude, angle), and
// the other form is recomputed; the out_ stream returns all four components
// plus the saturation flag for every request.
// Writing x or y: the sum of squares goes through the shared multiplier, a
// bit-serial square root gives the magnitude one bit per cycle, then the
// cordic unit runs 30 vectoring steps for the angle.
// Writing magnitude or angle: one multiply by the inverse cordic gain, then
// 30 rotation steps.
// One request is in work at a time: in_tready is high only while the
// sequencer is idle, so a new request is taken only after the sequencer has
// finished the last one. A finished result waits in the output register; a
// new request is accepted meanwhile, and its result waits in the last step
// until out_tready frees the register. Reset clears all four components to
// zero and drops out_tvalid.

module polar_cartesian_vector_register_unit
  import pcvr_pkg::*;
#(
  parameter int LENGTH_BITS = 24,
  parameter int ANGLE_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: length_value, angle_value
  input  logic [((LENGTH_BITS+ANGLE_BITS+7)/8)*8-1:0]   in_tdata,
  // in_tuser: kind
  input  logic [1:0]                                    in_tuser,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // out_tdata: out_x, out_y, out_magnitude, out_angle
  output logic [((3*LENGTH_BITS+ANGLE_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser: saturated
  output logic                                          out_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready
);

  localparam int L      = LENGTH_BITS;
  localparam int A      = ANGLE_BITS;
  localparam int W      = L + GUARD_SHIFT + 3;
  localparam int RW     = W - GUARD_SHIFT;
  localparam int MB     = (L + 1 > 25) ? L + 1 : 25;
  localparam int PW     = L + 1 + MB;
  localparam int OUT_W  = ((3*L+A+7)/8)*8;
  localparam int CNT_W  = ($clog2(L) > IDX_W) ? $clog2(L) : IDX_W;
  localparam logic signed [L-1:0] MAXL = {1'b0, {(L-1){1'b1}}};
  localparam logic signed [L-1:0] MINL = {1'b1, {(L-1){1'b0}}};

  // saturate a rounded cordic output to the length range
  function automatic logic signed [L-1:0] clamp_len(input logic signed [RW-1:0] v);
    logic signed [L-1:0] r;
    if ((v[RW-1:L-1] == '0) || (v[RW-1:L-1] == '1)) begin
      r = v[L-1:0];
    end else if (v[RW-1]) begin
      r = MINL;
    end else begin
      r = MAXL;
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             polar_r;

  logic signed [L-1:0] stored_x_r, stored_x_nxt;
  logic signed [L-1:0] stored_y_r, stored_y_nxt;
  logic signed [L-1:0] stored_mag_r, stored_mag_nxt;
  logic [A-1:0]        stored_ang_r, stored_ang_nxt;

  logic signed [L-1:0] out_x_r, out_y_r, out_mag_r;
  logic [A-1:0]        out_ang_r;
  logic                out_sat_r;
  logic                out_valid_r;

  logic                in_accept;
  logic                done_go;
  logic [1:0]          in_kind;
  logic signed [L-1:0] in_len;
  logic [A-1:0]        in_ang;

  mul_sel_t            mul_sel;
  sqrt_ctrl_t          sqrt_ctrl;
  cordic_ctrl_t        cordic_ctrl;

  logic signed [L:0]    mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_r;
  logic [2*L-1:0]       acc_r;

  logic signed [W-1:0]  vec_x, vec_y;
  logic                 x_neg;
  logic [31:0]          rot_z_raw;
  logic                 rot_flip;
  logic signed [L:0]    mag_ext, mag_adj;
  logic signed [W-1:0]  cord_ld_x, cord_ld_y;
  logic [31:0]          cord_ld_z;
  logic signed [W-1:0]  cv_x, cv_y;
  logic [31:0]          cv_z;

  logic [L:0]           root_round;
  logic                 sat_calc;
  logic signed [L-1:0]  mag_final;
  logic [31:0]          z_round;
  logic [A-1:0]         ang_final;
  logic signed [W-1:0]  rx_full, ry_full;
  logic signed [L-1:0]  x_final, y_final;

  // input field unpacking and handshake
  assign in_kind   = in_tuser;
  assign in_len    = in_tdata[L-1:0];
  assign in_ang    = in_tdata[L+A-1:L];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign done_go   = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_kind == KIND_X || in_kind == KIND_Y) ? ST_MUL_X : ST_ROT_LOAD;
        end
      end
      ST_MUL_X: state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == CNT_W'(L - 1)) state_nxt = ST_VEC;
      end
      ST_VEC: begin
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_ROT_LOAD: state_nxt = ST_ROT;
      ST_ROT: begin
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (done_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_sel               = MUL_SEL_GAIN;
    sqrt_ctrl             = '0;
    cordic_ctrl           = '0;
    cordic_ctrl.idx       = cnt_r[IDX_W-1:0];
    cordic_ctrl.vectoring = (state_r == ST_VEC);
    case (state_r)
      ST_MUL_X:    mul_sel = MUL_SEL_X;
      ST_MUL_Y:    mul_sel = MUL_SEL_Y;
      ST_ACC: begin
        sqrt_ctrl.load   = 1'b1;
        cordic_ctrl.load = 1'b1;
      end
      ST_SQRT:     sqrt_ctrl.step = 1'b1;
      ST_VEC:      cordic_ctrl.step = 1'b1;
      ST_ROT_LOAD: cordic_ctrl.load = 1'b1;
      ST_ROT:      cordic_ctrl.step = 1'b1;
      default: ;
    endcase
  end

  // state, step counter and path flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      polar_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else if (state_r == ST_SQRT || state_r == ST_VEC || state_r == ST_ROT) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (in_accept) polar_r <= ~in_kind[1];
    end
  end

  // shared multiplier: squares of x and y, or magnitude times inverse gain
  always_comb begin
    case (mul_sel)
      MUL_SEL_X: begin
        mul_a = (L+1)'(stored_x_r);
        mul_b = MB'(stored_x_r);
      end
      MUL_SEL_Y: begin
        mul_a = (L+1)'(stored_y_r);
        mul_b = MB'(stored_y_r);
      end
      default: begin
        mul_a = mag_adj;
        mul_b = MB'(INV_GAIN_Q24);
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // product register and sum of squares
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (state_r == ST_MUL_Y) acc_r <= prod_r[2*L-1:0];
  end

  // vectoring start: scale up, fold left half plane onto the right
  assign x_neg = stored_x_r[L-1];
  assign vec_x = W'(stored_x_r) <<< GUARD_SHIFT;
  assign vec_y = W'(stored_y_r) <<< GUARD_SHIFT;

  // rotation start: fold second and third quarter by a half turn
  assign rot_z_raw = {stored_ang_r, {(32-A){1'b0}}};
  assign rot_flip  = rot_z_raw[31] ^ rot_z_raw[30];
  assign mag_ext   = (L+1)'(stored_mag_r);
  assign mag_adj   = rot_flip ? -mag_ext : mag_ext;

  // cordic load values for either path
  always_comb begin
    if (state_r == ST_ACC) begin
      cord_ld_x = x_neg ? -vec_x : vec_x;
      cord_ld_y = x_neg ? -vec_y : vec_y;
      cord_ld_z = x_neg ? 32'h80000000 : 32'h00000000;
    end else begin
      cord_ld_x = W'(prod);
      cord_ld_y = '0;
      cord_ld_z = rot_z_raw ^ {rot_flip, 31'd0};
    end
  end

  pcvr_isqrt #(
    .LENGTH_BITS (L)
  ) u_isqrt (
    .clk        (clk),
    .ctrl       (sqrt_ctrl),
    .radicand   (acc_r + prod_r[2*L-1:0]),
    .root_round (root_round)
  );

  pcvr_cordic #(
    .DATA_W (W)
  ) u_cordic (
    .clk    (clk),
    .ctrl   (cordic_ctrl),
    .load_x (cord_ld_x),
    .load_y (cord_ld_y),
    .load_z (cord_ld_z),
    .vx     (cv_x),
    .vy     (cv_y),
    .vz     (cv_z)
  );

  // polar results: saturated magnitude, rounded angle, zero vector gives angle zero
  assign sat_calc  = (root_round[L:L-1] != 2'b00);
  assign mag_final = sat_calc ? MAXL : root_round[L-1:0];
  assign z_round   = cv_z + (32'd1 << (31 - A));
  assign ang_final = ((stored_x_r == '0) && (stored_y_r == '0)) ? '0 : z_round[31:32-A];

  // cartesian results: round off the guard bits, clamp to the length range
  assign rx_full = cv_x + (W'(1) <<< (GUARD_SHIFT - 1));
  assign ry_full = cv_y + (W'(1) <<< (GUARD_SHIFT - 1));
  assign x_final = clamp_len(rx_full[W-1:GUARD_SHIFT]);
  assign y_final = clamp_len(ry_full[W-1:GUARD_SHIFT]);

  // stored component update
  always_comb begin
    stored_x_nxt   = stored_x_r;
    stored_y_nxt   = stored_y_r;
    stored_mag_nxt = stored_mag_r;
    stored_ang_nxt = stored_ang_r;
    if (in_accept) begin
      case (in_kind)
        KIND_X:   stored_x_nxt = in_len;
        KIND_Y:   stored_y_nxt = in_len;
        KIND_MAG: stored_mag_nxt = in_len;
        KIND_ANG: stored_ang_nxt = in_ang;
        default:  stored_ang_nxt = in_ang;
      endcase
    end else if (done_go) begin
      if (polar_r) begin
        stored_mag_nxt = mag_final;
        stored_ang_nxt = ang_final;
      end else begin
        stored_x_nxt = x_final;
        stored_y_nxt = y_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_x_r   <= '0;
      stored_y_r   <= '0;
      stored_mag_r <= '0;
      stored_ang_r <= '0;
    end else begin
      stored_x_r   <= stored_x_nxt;
      stored_y_r   <= stored_y_nxt;
      stored_mag_r <= stored_mag_nxt;
      stored_ang_r <= stored_ang_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_x_r   <= stored_x_nxt;
      out_y_r   <= stored_y_nxt;
      out_mag_r <= stored_mag_nxt;
      out_ang_r <= stored_ang_nxt;
      out_sat_r <= polar_r & sat_calc;
    end
  end

  assign out_tdata  = OUT_W'({out_ang_r, out_mag_r, out_y_r, out_x_r});
  assign out_tuser  = out_sat_r;
  assign out_tvalid = out_valid_r;

  // checks
  `PCVR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, state_r != ST_IDLE, "accepted request did not start work")
  `PCVR_ASSERT_NOW(a_sat_means_max, clk, rst_n, !(out_valid_r && out_sat_r) || (out_mag_r == MAXL), "saturation flag without clipped magnitude")
  `PCVR_ASSERT_NEXT(a_done_delivers, clk, rst_n, state_r == ST_DONE && !out_valid_r, state_r == ST_IDLE && out_valid_r, "finished result not delivered to output register")

endmodule
